// File: rtl/dotf_pkg.sv
// ----------------------------------------------------------------------------
// dotf_pkg - shared types and constants for the DHCP option tag finder
// Field widths, header walk phases, result status codes and parameter defaults.
// ----------------------------------------------------------------------------
package dotf_pkg;

	// fixed field widths
	localparam int POS_W  = 12;
	localparam int BYTE_W = 8;
	localparam int WORD_W = 32;
	localparam int CNT_W  = 3;

	// parameter defaults
	localparam int HEADER_BYTES_DEF = 236;
	localparam int COOKIE_BYTES_DEF = 4;
	localparam int MAX_BYTES_DEF    = 2048;

	// reset value of the search tag (DHCP message type)
	localparam logic [BYTE_W-1:0] SEARCH_TAG_RST = 8'd53;

	// value bytes captured at most
	localparam logic [CNT_W-1:0] CAPTURE_MAX = 3'd4;

	// header walk phase
	typedef enum logic [1:0] {
		PH_TYPE  = 2'd0,
		PH_LEN   = 2'd1,
		PH_VALUE = 2'd2
	} phase_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_NOT_FOUND = 2'd0,
		ST_FOUND     = 2'd1,
		ST_TOO_LONG  = 2'd2
	} status_t;

endpackage

// File: rtl/dhcp_option_tag_finder_unit.sv
// ----------------------------------------------------------------------------
// dhcp_option_tag_finder_unit - DHCP option TLV search
// Walks the option headers of a DHCP message, one byte per beat, and reports
// the first option whose type equals search_tag, with up to four value bytes.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | dir
//  ---------+-------------------------------------------+-----
//  in       | in_valid, in_ready, data_byte, last_byte  | in
//  out      | out_valid, out_ready, status,             | out
//           | tag_position, tag_length, value_word      |
//  cfg      | cfg_we, cfg_wdata (search_tag)            | in
//
// One byte per cycle while no last byte is held: an accepted beat sits in the
// _s1 register, the header walk updates state from it, and the last byte
// loads the result register, which drives out_valid.
// Reset clears control state and restores search_tag to 53.
// A last byte holds in _s1 only while an earlier result waits untaken;
// other bytes never stall.
// ----------------------------------------------------------------------------
module dhcp_option_tag_finder_unit
	import dotf_pkg::*;
#(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int COOKIE_BYTES = COOKIE_BYTES_DEF,
	parameter int MAX_BYTES    = MAX_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic [BYTE_W-1:0] cfg_wdata,
	// input beats
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	// result beats
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [POS_W-1:0]  tag_position,
	output logic [BYTE_W-1:0] tag_length,
	output logic [WORD_W-1:0] value_word
);

	localparam int OPT_START_I = (HEADER_BYTES + COOKIE_BYTES > MAX_BYTES) ?
		MAX_BYTES : HEADER_BYTES + COOKIE_BYTES;
	localparam logic [POS_W-1:0] MAX_POS   = POS_W'(MAX_BYTES);
	localparam logic [POS_W-1:0] OPT_START = POS_W'(OPT_START_I);

	// configuration register
	logic [BYTE_W-1:0] search_tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_tag_q <= SEARCH_TAG_RST;
		end else if (cfg_we) begin
			search_tag_q <= cfg_wdata;
		end
	end

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              last_s1;
	logic              adv_s1;
	logic              res_load;

	assign res_load = !out_valid || out_ready;
	assign adv_s1   = valid_s1 && (!last_s1 || res_load);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// walk state
	logic [POS_W-1:0]  byte_pos_q;
	logic [POS_W-1:0]  next_hdr_q;
	phase_t            phase_q;
	logic              match_seen_q;
	logic [POS_W-1:0]  match_pos_q;
	logic [BYTE_W-1:0] match_len_q;
	logic [WORD_W-1:0] cap_val_q;
	logic [CNT_W-1:0]  cap_cnt_q;

	logic              processed;
	logic              at_header;
	logic              tag_hit;

	assign processed = byte_pos_q < MAX_POS;
	assign at_header = byte_pos_q == next_hdr_q;
	assign tag_hit   = data_s1 == search_tag_q;

	// phase next state
	phase_t phase_d;

	always_comb begin
		phase_d = phase_q;
		if (processed) begin
			case (phase_q)
				PH_TYPE: begin
					if (at_header) phase_d = PH_LEN;
				end
				PH_LEN: begin
					phase_d = match_seen_q ? PH_VALUE : PH_TYPE;
				end
				PH_VALUE: begin
					phase_d = PH_VALUE;
				end
				default: begin
					phase_d = PH_TYPE;
				end
			endcase
		end
	end

	// datapath next values
	logic [POS_W-1:0]  byte_pos_d;
	logic [POS_W-1:0]  next_hdr_d;
	logic              match_seen_d;
	logic [POS_W-1:0]  match_pos_d;
	logic [BYTE_W-1:0] match_len_d;
	logic [WORD_W-1:0] cap_val_d;
	logic [CNT_W-1:0]  cap_cnt_d;
	logic [POS_W:0]    hop_sum;
	logic [CNT_W-1:0]  want;

	always_comb begin
		byte_pos_d   = byte_pos_q;
		next_hdr_d   = next_hdr_q;
		match_seen_d = match_seen_q;
		match_pos_d  = match_pos_q;
		match_len_d  = match_len_q;
		cap_val_d    = cap_val_q;
		cap_cnt_d    = cap_cnt_q;
		hop_sum      = {1'b0, byte_pos_q} + {{(POS_W+1-BYTE_W){1'b0}}, data_s1} +
			(POS_W+1)'(1);
		want         = (match_len_q < BYTE_W'(CAPTURE_MAX)) ?
			match_len_q[CNT_W-1:0] : CAPTURE_MAX;
		if (processed) begin
			case (phase_q)
				PH_TYPE: begin
					if (at_header && tag_hit) begin
						match_seen_d = 1'b1;
						match_pos_d  = byte_pos_q;
					end
				end
				PH_LEN: begin
					if (match_seen_q) begin
						match_len_d = data_s1;
					end else begin
						next_hdr_d = (hop_sum > {1'b0, MAX_POS}) ?
							MAX_POS : hop_sum[POS_W-1:0];
					end
				end
				PH_VALUE: begin
					if (cap_cnt_q < want) begin
						case (cap_cnt_q[1:0])
							2'd0:    cap_val_d = cap_val_q | {data_s1, 24'd0};
							2'd1:    cap_val_d = cap_val_q | {8'd0, data_s1, 16'd0};
							2'd2:    cap_val_d = cap_val_q | {16'd0, data_s1, 8'd0};
							default: cap_val_d = cap_val_q | {24'd0, data_s1};
						endcase
						cap_cnt_d = cap_cnt_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
			byte_pos_d = byte_pos_q + 1'b1;
		end
	end

	// result decision from the updated state
	logic [POS_W:0]   near_end;
	logic [POS_W+1:0] val_end;
	logic [POS_W:0]   msg_len;
	logic             res_hit;
	status_t          res_status;

	always_comb begin
		msg_len    = {1'b0, byte_pos_d};
		near_end   = {1'b0, match_pos_d} + (POS_W+1)'(2);
		val_end    = {1'b0, near_end} + {{(POS_W+2-BYTE_W){1'b0}}, match_len_d};
		res_hit    = processed && match_seen_d && (near_end < msg_len);
		res_status = ST_NOT_FOUND;
		if (res_hit) begin
			res_status = (val_end <= {1'b0, msg_len}) ? ST_FOUND : ST_TOO_LONG;
		end
	end

	// state registers; the last byte returns the walk to its start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q   <= '0;
			next_hdr_q   <= OPT_START;
			phase_q      <= PH_TYPE;
			match_seen_q <= 1'b0;
			match_pos_q  <= '0;
			match_len_q  <= '0;
			cap_val_q    <= '0;
			cap_cnt_q    <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				byte_pos_q   <= '0;
				next_hdr_q   <= OPT_START;
				phase_q      <= PH_TYPE;
				match_seen_q <= 1'b0;
				match_pos_q  <= '0;
				match_len_q  <= '0;
				cap_val_q    <= '0;
				cap_cnt_q    <= '0;
			end else begin
				byte_pos_q   <= byte_pos_d;
				next_hdr_q   <= next_hdr_d;
				phase_q      <= phase_d;
				match_seen_q <= match_seen_d;
				match_pos_q  <= match_pos_d;
				match_len_q  <= match_len_d;
				cap_val_q    <= cap_val_d;
				cap_cnt_q    <= cap_cnt_d;
			end
		end
	end

	// result register
	logic              out_valid_q;
	status_t           status_q;
	logic [POS_W-1:0]  tag_pos_q;
	logic [BYTE_W-1:0] tag_len_q;
	logic [WORD_W-1:0] value_q;
	logic              res_take;

	assign res_take = adv_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= res_take;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			status_q  <= res_status;
			tag_pos_q <= res_hit ? match_pos_d : '0;
			tag_len_q <= res_hit ? match_len_d : '0;
			value_q   <= res_hit ? cap_val_d : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign tag_position = tag_pos_q;
	assign tag_length   = tag_len_q;
	assign value_word   = value_q;

`ifndef ASSERT_OFF
	// a not-found result carries all-zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_NOT_FOUND) |->
		(tag_position == '0 && tag_length == '0 && value_word == '0))
		else $error("not-found result with nonzero fields");

	// the position count saturates at the stream limit
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= MAX_POS)
		else $error("byte position past limit");

	// value capture only follows a match
	a_value_match: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_VALUE) |-> match_seen_q)
		else $error("value phase without match");

	// never more than four value bytes captured
	a_cap_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cap_cnt_q <= CAPTURE_MAX)
		else $error("capture count overflow");
`endif

endmodule
